FILE: rtl/prws_pkg.sv
package prws_pkg;

  localparam int unsigned TimeW    = 64;
  localparam int unsigned ValueW   = 22;
  localparam int unsigned SpanW    = 32;
  localparam int unsigned PortPayW = 32;
  localparam int unsigned MsToUs   = 1000;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_COUNT  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_SPAN   = 2'd2,
    MODE_SPARE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_ACK    = 2'd0,
    KIND_RECORD = 2'd1,
    KIND_EMPTY  = 2'd2,
    KIND_SPARE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DROPPED = 2'd1,
    ST_EVICTED = 2'd2,
    ST_SPARE   = 2'd3
  } status_e;

  localparam logic [1:0] CfgMode  = 2'd0;
  localparam logic [1:0] CfgValue = 2'd1;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

FILE: rtl/prws_cell.sv
module prws_cell import prws_pkg::*; #(
  parameter int unsigned PW = 32
) (
  input  logic             clk_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic [TimeW-1:0] wr_time_i,
  input  logic [1:0]       wr_dir_i,
  input  logic [PW-1:0]    wr_pay_i,
  input  logic [TimeW-1:0] nb_time_i,
  input  logic [1:0]       nb_dir_i,
  input  logic [PW-1:0]    nb_pay_i,
  output logic [TimeW-1:0] time_o,
  output logic [1:0]       dir_o,
  output logic [PW-1:0]    pay_o
);

  logic [TimeW-1:0] time_q;
  logic [1:0]       dir_q;
  logic [PW-1:0]    pay_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      time_q <= nb_time_i;
      dir_q  <= nb_dir_i;
      pay_q  <= nb_pay_i;
    end else if (ctrl_i.load) begin
      time_q <= wr_time_i;
      dir_q  <= wr_dir_i;
      pay_q  <= wr_pay_i;
    end
  end

  assign time_o = time_q;
  assign dir_o  = dir_q;
  assign pay_o  = pay_q;

endmodule

FILE: rtl/packet_record_window_store.sv
// packet_record_window_store
// Input channel (in_valid_i / in_stall_o) takes one word per op: write a
// record, read all records, or clear. Output channel (out_valid_o /
// out_stall_i) returns results through a single output register.
// Write and clear: one acknowledge, available the cycle after acceptance;
// a new word is taken each cycle while the output register drains.
// Read: the records sit in a ring of cells that rotates one slot per cycle
// toward cell 0 while a readout advances. A readout rotates the ring three
// full turns: the first turn finds the newest stamp, the second (running on
// into the third) emits records oldest to newest, in span mode only those
// within the span of the newest, and the ring ends where it began. Input is
// stalled for the whole walk. An empty read gives one marker word at once.
// A stalled output holds its word; the walk pauses when a record is ready
// and both the output register and the one-record hold buffer are full.
// Reset empties the store, sets mode 0 with value 32; record contents are
// undefined until written. Config writes must be made while idle; writes to
// mode or value also empty the store.
module packet_record_window_store import prws_pkg::*; #(
  parameter int unsigned DEPTH        = 32,
  parameter int unsigned GROW_STEP    = 8,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          op_i,
  input  logic [TimeW-1:0]    timestamp_i,
  input  logic [1:0]          direction_i,
  input  logic [PortPayW-1:0] payload_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          kind_o,
  output logic [1:0]          status_o,
  output logic [TimeW-1:0]    record_time_o,
  output logic [1:0]          record_direction_o,
  output logic [PortPayW-1:0] record_payload_o,
  output logic                last_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [ValueW-1:0]   cfg_wdata_i
);

  localparam int unsigned IW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned SW  = $clog2(3 * DEPTH + 1);
  localparam int unsigned PW  = (PAYLOAD_BITS < PortPayW) ? PAYLOAD_BITS : PortPayW;
  localparam int unsigned RING0 = (GROW_STEP < DEPTH) ? GROW_STEP : DEPTH;

  logic [TimeW-1:0] c_time [DEPTH];
  logic [1:0]       c_dir  [DEPTH];
  logic [PW-1:0]    c_pay  [DEPTH];
  cell_ctrl_t       c_ctrl [DEPTH];

  logic [1:0]        mode_q;
  logic [ValueW-1:0] value_q;
  logic [SpanW-1:0]  span_q;
  logic [IW-1:0]     oldest_q, next_q;
  logic [CW-1:0]     count_q, ring_q;
  logic              busy_q;
  logic [SW-1:0]     step_q;
  logic [TimeW-1:0]  newest_time_q;
  logic              pend_q;
  logic [TimeW-1:0]  pend_time_q;
  logic [1:0]        pend_dir_q;
  logic [PW-1:0]     pend_pay_q;

  logic              out_valid_q;
  logic [1:0]        kind_q, status_q, odir_q;
  logic [TimeW-1:0]  otime_q;
  logic [PW-1:0]     opay_q;
  logic              last_q;

  logic out_free, in_acc, empty_all;
  logic put, oldest_inc, count_inc, ring_inc;
  logic [1:0] wr_status;
  logic [CW-1:0] n_clamp;
  logic [IW-1:0] newest;
  logic walking, done, in_win, keep, advance;
  logic [SW-1:0] win_lo;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = busy_q || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // write decision
  always_comb begin
    put        = 1'b0;
    oldest_inc = 1'b0;
    count_inc  = 1'b0;
    ring_inc   = 1'b0;
    wr_status  = ST_OK;
    if (value_q == '0) begin
      n_clamp = CW'(1);
    end else if (value_q > ValueW'(DEPTH)) begin
      n_clamp = CW'(DEPTH);
    end else begin
      n_clamp = CW'(value_q);
    end
    case (mode_q)
      MODE_COUNT: begin
        put = 1'b1;
        if (count_q >= n_clamp) oldest_inc = 1'b1;
        else count_inc = 1'b1;
      end
      MODE_SPAN: begin
        put = 1'b1;
        if (count_q < ring_q) begin
          count_inc = 1'b1;
        end else if (timestamp_i - c_time[oldest_q] > {32'd0, span_q}) begin
          oldest_inc = 1'b1;
        end else if (ring_q < CW'(DEPTH)) begin
          ring_inc  = 1'b1;
          count_inc = 1'b1;
        end else begin
          oldest_inc = 1'b1;
          wr_status  = ST_EVICTED;
        end
      end
      default: begin
        if (count_q >= CW'(DEPTH)) begin
          wr_status = ST_DROPPED;
        end else begin
          put       = 1'b1;
          count_inc = 1'b1;
        end
      end
    endcase
  end

  // readout walk
  assign newest  = (next_q == '0) ? IW'(DEPTH - 1) : next_q - IW'(1);
  assign walking = busy_q && (step_q < SW'(3 * DEPTH));
  assign done    = busy_q && (step_q == SW'(3 * DEPTH));
  assign win_lo  = SW'(DEPTH) + SW'(oldest_q);
  assign in_win  = (step_q >= win_lo) && (step_q < win_lo + SW'(count_q));
  assign keep    = (mode_q != MODE_SPAN) ||
                   ((newest_time_q - c_time[0]) <= {32'd0, span_q});
  assign advance = walking && !(in_win && keep && pend_q && !out_free);

  assign empty_all = cfg_we_i && (cfg_index_i == CfgMode || cfg_index_i == CfgValue);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign c_ctrl[i].shift = advance;
    assign c_ctrl[i].load  = in_acc && (op_i == OP_WRITE) && put && (next_q == IW'(i));
    prws_cell #(.PW(PW)) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (c_ctrl[i]),
      .wr_time_i (timestamp_i),
      .wr_dir_i  (direction_i),
      .wr_pay_i  (payload_i[PW-1:0]),
      .nb_time_i (c_time[(i + 1) % DEPTH]),
      .nb_dir_i  (c_dir[(i + 1) % DEPTH]),
      .nb_pay_i  (c_pay[(i + 1) % DEPTH]),
      .time_o    (c_time[i]),
      .dir_o     (c_dir[i]),
      .pay_o     (c_pay[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_COUNT;
      value_q     <= ValueW'(32);
      span_q      <= SpanW'(32 * MsToUs);
      oldest_q    <= '0;
      next_q      <= '0;
      count_q     <= '0;
      ring_q      <= CW'(RING0);
      busy_q      <= 1'b0;
      step_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_free) out_valid_q <= 1'b0;
      if (empty_all) begin
        if (cfg_index_i == CfgMode) begin
          mode_q <= cfg_wdata_i[1:0];
        end else begin
          value_q <= cfg_wdata_i;
          span_q  <= SpanW'(cfg_wdata_i) * SpanW'(MsToUs);
        end
        oldest_q <= '0;
        next_q   <= '0;
        count_q  <= '0;
        ring_q   <= CW'(RING0);
      end else if (in_acc) begin
        case (op_i)
          OP_WRITE: begin
            if (put) next_q <= (next_q == IW'(DEPTH - 1)) ? '0 : next_q + IW'(1);
            if (oldest_inc) oldest_q <= (oldest_q == IW'(DEPTH - 1)) ? '0 : oldest_q + IW'(1);
            if (count_inc) count_q <= count_q + CW'(1);
            if (ring_inc) ring_q <= ring_q + CW'(1);
            out_valid_q <= 1'b1;
            kind_q      <= KIND_ACK;
            status_q    <= wr_status;
            otime_q     <= '0;
            odir_q      <= '0;
            opay_q      <= '0;
            last_q      <= 1'b1;
          end
          OP_READ: begin
            if (count_q == '0) begin
              out_valid_q <= 1'b1;
              kind_q      <= KIND_EMPTY;
              status_q    <= ST_OK;
              otime_q     <= '0;
              odir_q      <= '0;
              opay_q      <= '0;
              last_q      <= 1'b1;
            end else begin
              busy_q <= 1'b1;
              step_q <= '0;
              pend_q <= 1'b0;
            end
          end
          OP_CLEAR: begin
            oldest_q    <= '0;
            next_q      <= '0;
            count_q     <= '0;
            ring_q      <= CW'(RING0);
            out_valid_q <= 1'b1;
            kind_q      <= KIND_ACK;
            status_q    <= ST_OK;
            otime_q     <= '0;
            odir_q      <= '0;
            opay_q      <= '0;
            last_q      <= 1'b1;
          end
          default: ;
        endcase
      end else if (advance) begin
        step_q <= step_q + SW'(1);
        if (step_q == SW'(newest)) newest_time_q <= c_time[0];
        if (in_win && keep) begin
          if (pend_q) begin
            out_valid_q <= 1'b1;
            kind_q      <= KIND_RECORD;
            status_q    <= ST_OK;
            otime_q     <= pend_time_q;
            odir_q      <= pend_dir_q;
            opay_q      <= pend_pay_q;
            last_q      <= 1'b0;
          end
          pend_q      <= 1'b1;
          pend_time_q <= c_time[0];
          pend_dir_q  <= c_dir[0];
          pend_pay_q  <= c_pay[0];
        end
      end else if (done && out_free) begin
        busy_q      <= 1'b0;
        pend_q      <= 1'b0;
        out_valid_q <= 1'b1;
        kind_q      <= KIND_RECORD;
        status_q    <= ST_OK;
        otime_q     <= pend_time_q;
        odir_q      <= pend_dir_q;
        opay_q      <= pend_pay_q;
        last_q      <= 1'b1;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign kind_o             = kind_q;
  assign status_o           = status_q;
  assign record_time_o      = otime_q;
  assign record_direction_o = odir_q;
  assign record_payload_o   = PortPayW'(opay_q);
  assign last_o             = last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH) && count_q <= ring_q || mode_q != MODE_SPAN)
    else $error("record count exceeds ring");
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> in_stall_o)
    else $error("input accepted during readout");
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= SW'(3 * DEPTH))
    else $error("walk step out of range");
  a_done_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> pend_q)
    else $error("readout ended without newest record");

endmodule
